### hw/rtl/emt_pkg.sv
// Shared constants and types of the encoder multi-turn tracker.
`timescale 1ns / 1ps
`default_nettype none

package emt_pkg;

   localparam int unsigned AXES_DEF = 2;

   // Event codes carried in the input word's tuser.
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_SAMPLE  = 2'd2;
   localparam logic [1:0] OP_ERROR   = 2'd3;

   // Register index codes, taken from csr_paddr[2].
   localparam logic CSR_READY_MASK = 1'b0;
   localparam logic CSR_MAX_AGE    = 1'b1;

   // Status byte bit positions.
   localparam int unsigned STATUS_STRONG_BIT = 3;
   localparam int unsigned STATUS_WEAK_BIT   = 4;
   localparam int unsigned STATUS_DETECT_BIT = 5;

   localparam logic [3:0]         ANGLE_HIGH_MASK = 4'hF;
   localparam logic signed [13:0] HALF_REV        = 14'sd2048;
   localparam logic signed [13:0] FULL_REV        = 14'sd4096;
   localparam logic [15:0]        AGE_LIMIT_RESET = 16'd10;
   localparam logic [15:0]        AGE_MAX         = 16'hFFFF;

   // One axis entry of the state memory.
   typedef struct packed {
      logic [11:0] last_angle;
      logic [31:0] multi_count;
      logic        seeded;
      logic        flag_detect;
      logic        flag_weak;
      logic        flag_strong;
      logic        pending;
      logic [31:0] samples_seen;
      logic [31:0] errors_seen;
      logic [31:0] skips_seen;
   } axis_rec_type;

   // Result word, lowest field in the lowest bits.
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] skip_total;
      logic [31:0] error_total;
      logic [31:0] sample_total;
      logic        busy_res;
      logic        angle_valid;
      logic        mag_strong;
      logic        mag_weak;
      logic        mag_present;
      logic        sampled;
      logic [31:0] turn_count;
      logic [11:0] single_turn;
      logic        request_issued;
   } rsp_word_type;

endpackage

`default_nettype wire

### hw/rtl/encoder_multiturn_tracker.sv
// Multi-turn angle tracker for a set of magnetic encoder axes.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  req_* carries one event word per handshake: a millisecond tick, a read
//  request, an arriving sample or a read error, for the axis in tuser.
//  rsp_* returns exactly one result word per event, in order, describing
//  that axis after the event. csr_* is an APB-style port with ready_mask
//  at byte address 0 and max_age_ticks at byte address 4; pready is tied
//  high and a read returns the register value.
//  Event words pass the accept stage, then the result register.
//  Throughput: one event per cycle while rsp_tready is high, set by the single
//  read-modify-write pass through the axis state memory (read on accept,
//  written at exit); a same-axis write back is forwarded to the next word.
//  Per-axis sample ages sit in flip-flops, since a tick ages every axis.
//  Reset: synchronous; all axis state reads as zero right after reset
//  through per-entry valid bits, so no clearing pass is needed.
//  Stall: when rsp_tready is low the result word holds, one more event is
//  still taken into the memory stage, and req_tready then drops.
module encoder_multiturn_tracker #(
   parameter int unsigned AXES = emt_pkg::AXES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // input words
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // status_byte, angle_high, angle_low
   input  wire logic [2:0]   req_tuser,   // op[1:0], axis[2]
   // result words
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // request_issued, single_turn, turn_count, sampled, mag_present,
   // mag_weak, mag_strong, angle_valid, busy_res,
   // sample_total, error_total, skip_total, zero pad
   output logic [151:0]      rsp_tdata,
   // configuration
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int unsigned AXW      = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic        AXIS1_OK = (AXES > 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]  ready_mask_ff, ready_mask_in;
   logic [15:0] max_age_ff, max_age_in;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ready_mask_in = ready_mask_ff;
      max_age_in    = max_age_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            emt_pkg::CSR_READY_MASK: ready_mask_in = csr_pwdata[1:0];
            emt_pkg::CSR_MAX_AGE:    max_age_in    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         emt_pkg::CSR_READY_MASK: csr_prdata = {30'd0, ready_mask_ff};
         emt_pkg::CSR_MAX_AGE:    csr_prdata = {16'd0, max_age_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake and pipeline control
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire, s1_fire;

   // Advance the memory stage whenever the result register is free or drains.
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Accept stage: latch the event word and issue the memory read
   // ---------------------------------------------------------------------
   logic           req_axis;
   logic [AXW-1:0] req_idx;

   assign req_axis = req_tuser[2];
   assign req_idx  = AXW'(req_axis);

   logic [1:0]     s1_op_ff;
   logic           s1_axis_ff;
   logic           s1_axis_ok_ff;
   logic [7:0]     s1_status_ff;
   logic [11:0]    s1_angle_ff;
   logic [AXW-1:0] s1_idx;

   assign s1_idx = AXW'(s1_axis_ff);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff      <= req_tuser[1:0];
         s1_axis_ff    <= req_axis;
         s1_axis_ok_ff <= (req_axis == 1'b0) || AXIS1_OK;
         s1_status_ff  <= req_tdata[7:0];
         s1_angle_ff   <= {req_tdata[11:8] & emt_pkg::ANGLE_HIGH_MASK, req_tdata[23:16]};
      end
   end

   // ---------------------------------------------------------------------
   // Axis state memory, one read and one write port
   // ---------------------------------------------------------------------
   emt_pkg::axis_rec_type state_mem [AXES];
   emt_pkg::axis_rec_type rd_rec_ff;
   logic                  rd_ok_ff;
   logic [AXES-1:0]       entry_valid_ff, entry_valid_in;
   emt_pkg::axis_rec_type new_rec;
   logic                  mem_write;

   assign mem_write = s1_fire && s1_axis_ok_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_rec_ff <= state_mem[req_idx];
      end
      if (mem_write) begin
         state_mem[s1_idx] <= new_rec;
      end
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (mem_write) begin
         entry_valid_in[s1_idx] = 1'b1;
      end
   end

   // Hold the last write back so a same-axis word read in that cycle sees it.
   logic                  fwd_valid_ff;
   logic [AXW-1:0]        fwd_idx_ff;
   emt_pkg::axis_rec_type fwd_rec_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ok_ff <= entry_valid_ff[req_idx];
      end
      if (mem_write) begin
         fwd_idx_ff <= s1_idx;
         fwd_rec_ff <= new_rec;
      end
   end

   // ---------------------------------------------------------------------
   // Modify stage
   // ---------------------------------------------------------------------
   emt_pkg::axis_rec_type cur_rec;
   logic                  issued;
   logic signed [13:0]    diff;
   logic                  axis_ready;

   assign axis_ready = ready_mask_ff[s1_axis_ff];

   always_comb begin
      // Unwritten entries read as zero.
      if (fwd_valid_ff && (fwd_idx_ff == s1_idx)) begin
         cur_rec = fwd_rec_ff;
      end else if (rd_ok_ff) begin
         cur_rec = rd_rec_ff;
      end else begin
         cur_rec = '0;
      end

      new_rec = cur_rec;
      issued  = 1'b0;
      diff    = $signed({2'b00, s1_angle_ff}) - $signed({2'b00, cur_rec.last_angle});
      if (diff > emt_pkg::HALF_REV) begin
         diff = diff - emt_pkg::FULL_REV;
      end else if (diff < -emt_pkg::HALF_REV) begin
         diff = diff + emt_pkg::FULL_REV;
      end

      case (s1_op_ff)
         emt_pkg::OP_REQUEST: begin
            if (axis_ready) begin
               if (cur_rec.pending) begin
                  new_rec.skips_seen = cur_rec.skips_seen + 32'd1;
               end else begin
                  new_rec.pending = 1'b1;
                  issued          = 1'b1;
               end
            end
         end
         emt_pkg::OP_SAMPLE: begin
            new_rec.flag_detect = s1_status_ff[emt_pkg::STATUS_DETECT_BIT];
            new_rec.flag_weak   = s1_status_ff[emt_pkg::STATUS_WEAK_BIT];
            new_rec.flag_strong = s1_status_ff[emt_pkg::STATUS_STRONG_BIT];
            if (!cur_rec.seeded) begin
               // First sample seeds the count.
               new_rec.multi_count = {20'd0, s1_angle_ff};
               new_rec.seeded      = 1'b1;
            end else begin
               new_rec.multi_count = cur_rec.multi_count + {{18{diff[13]}}, diff};
            end
            new_rec.last_angle   = s1_angle_ff;
            new_rec.samples_seen = cur_rec.samples_seen + 32'd1;
            new_rec.pending      = 1'b0;
         end
         emt_pkg::OP_ERROR: begin
            new_rec.pending     = 1'b0;
            new_rec.errors_seen = cur_rec.errors_seen + 32'd1;
         end
         default: ;
      endcase
   end

   // Sample ages: a tick ages every axis, saturating; a sample clears its own.
   logic [15:0] age_ff   [AXES];
   logic [15:0] age_next [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         age_next[i] = age_ff[i];
         if ((s1_op_ff == emt_pkg::OP_TICK) && (age_ff[i] != emt_pkg::AGE_MAX)) begin
            age_next[i] = age_ff[i] + 16'd1;
         end
         if ((s1_op_ff == emt_pkg::OP_SAMPLE) && s1_axis_ok_ff && (AXW'(i) == s1_idx)) begin
            age_next[i] = 16'd0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   emt_pkg::rsp_word_type rsp_word;
   emt_pkg::rsp_word_type rsp_data_ff;
   logic                  age_ok;

   assign age_ok = s1_axis_ok_ff && (age_next[s1_idx] <= max_age_ff);

   always_comb begin
      rsp_word = '0;
      if (s1_axis_ok_ff) begin
         rsp_word.request_issued = issued;
         rsp_word.single_turn    = new_rec.last_angle;
         rsp_word.turn_count     = new_rec.multi_count;
         rsp_word.sampled        = new_rec.seeded;
         rsp_word.mag_present    = new_rec.flag_detect;
         rsp_word.mag_weak       = new_rec.flag_weak;
         rsp_word.mag_strong     = new_rec.flag_strong;
         rsp_word.angle_valid    = axis_ready && new_rec.seeded && new_rec.flag_detect
                                   && !new_rec.flag_weak && !new_rec.flag_strong && age_ok;
         rsp_word.busy_res       = new_rec.pending;
         rsp_word.sample_total   = new_rec.samples_seen;
         rsp_word.error_total    = new_rec.errors_seen;
         rsp_word.skip_total     = new_rec.skips_seen;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= rsp_word;
      end
   end

   assign rsp_tdata = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_mask_ff  <= 2'd0;
         max_age_ff     <= emt_pkg::AGE_LIMIT_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         fwd_valid_ff   <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            age_ff[i] <= 16'd0;
         end
      end else begin
         ready_mask_ff  <= ready_mask_in;
         max_age_ff     <= max_age_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_valid_ff <= entry_valid_in;
         if (mem_write) begin
            fwd_valid_ff <= 1'b1;
         end
         if (s1_fire) begin
            for (int i = 0; i < AXES; i++) begin
               age_ff[i] <= age_next[i];
            end
         end
      end
   end

endmodule

`default_nettype wire
